// File: src/arq_send_window_assert.svh
// assertion macros shared by the arq send window modules
`ifndef ARQ_SEND_WINDOW_ASSERT_SVH
`define ARQ_SEND_WINDOW_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ARQSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define ARQSW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARQSW_ASSERT(lbl, prop, msg)
`define ARQSW_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/arqsw_pkg.sv
// shared types, codes and constants of the arq send window
`timescale 1ns / 1ps
package arqsw_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;

    localparam int TAG_W  = 16;
    localparam int SEQ_W  = 8;
    localparam int TIME_W = 32;
    localparam int TOUT_W = 16;
    localparam int INIT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TOUT_W-1:0] TIMEOUT_RESET     = 16'd5;
    localparam logic [INIT_W-1:0] INIT_WINDOW_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 2'd1;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_ACK  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_SCAN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_RESEND  = 2'd1,
        KIND_TAKEN   = 2'd2,
        KIND_REFUSED = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ,
        ST_UPDATE,
        ST_SCAN_INIT,
        ST_RT_RD,
        ST_RT_CHK,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic enq;
        logic update;
        logic scan_init;
        logic rt_read;
        logic rt_skip;
        logic rt_issue;
        logic new_read;
        logic new_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic can_push;
        logic pend_valid;
        logic rt_more;
        logic rt_expired;
        logic new_more;
    } status_t;

endpackage

// File: src/arqsw_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module arqsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/arqsw_ctrl.sv
// sequencing state machine of the arq send window
`timescale 1ns / 1ps
`include "arq_send_window_assert.svh"
module arqsw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_action,
    output logic               in_ready,
    input  arqsw_pkg::status_t st,
    output arqsw_pkg::cmd_t    cmd
);

    arqsw_pkg::state_t state_reg;
    arqsw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arqsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            arqsw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (arqsw_pkg::action_t'(in_action))
                        arqsw_pkg::ACT_ENQ:  state_next = arqsw_pkg::ST_ENQ;
                        arqsw_pkg::ACT_SCAN: state_next = arqsw_pkg::ST_SCAN_INIT;
                        default:             state_next = arqsw_pkg::ST_UPDATE;
                    endcase
                end
            end
            arqsw_pkg::ST_ENQ:
            begin
                if (st.out_free)
                begin
                    cmd.enq    = 1'b1;
                    state_next = arqsw_pkg::ST_IDLE;
                end
            end
            arqsw_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = arqsw_pkg::ST_IDLE;
            end
            arqsw_pkg::ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = arqsw_pkg::ST_RT_RD;
            end
            arqsw_pkg::ST_RT_RD:
            begin
                if (st.rt_more)
                begin
                    cmd.rt_read = 1'b1;
                    state_next  = arqsw_pkg::ST_RT_CHK;
                end
                else
                begin
                    state_next = arqsw_pkg::ST_NEW_RD;
                end
            end
            arqsw_pkg::ST_RT_CHK:
            begin
                if (!st.rt_expired)
                begin
                    cmd.rt_skip = 1'b1;
                    state_next  = arqsw_pkg::ST_RT_RD;
                end
                else if (st.can_push)
                begin
                    cmd.rt_issue = 1'b1;
                    state_next   = arqsw_pkg::ST_RT_RD;
                end
            end
            arqsw_pkg::ST_NEW_RD:
            begin
                if (st.new_more)
                begin
                    cmd.new_read = 1'b1;
                    state_next   = arqsw_pkg::ST_NEW_WR;
                end
                else
                begin
                    state_next = arqsw_pkg::ST_FINISH;
                end
            end
            arqsw_pkg::ST_NEW_WR:
            begin
                if (st.can_push)
                begin
                    cmd.new_issue = 1'b1;
                    state_next    = arqsw_pkg::ST_NEW_RD;
                end
            end
            arqsw_pkg::ST_FINISH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = arqsw_pkg::ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = arqsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arqsw_pkg::ST_IDLE;
            end
        endcase
    end

    // at most one source loads the output register per cycle
    `ARQSW_ASSERT(a_one_push, $onehot0({cmd.enq, cmd.rt_issue, cmd.new_issue, cmd.finish}), "two output loads in one cycle")

endmodule

// File: src/arqsw_dp.sv
// window state, queue, slot store and output staging of the arq send window
`timescale 1ns / 1ps
`include "arq_send_window_assert.svh"
module arqsw_dp #(
    parameter int WINDOW_DEPTH = arqsw_pkg::WINDOW_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = arqsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arqsw_pkg::cmd_t                     cmd,
    output arqsw_pkg::status_t                  st,
    input  logic [31:0]                         in_data,
    input  logic [1:0]                          in_action,
    input  logic                                cfg_we,
    input  logic [arqsw_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [arqsw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_kind,
    output logic [arqsw_pkg::SEQ_W-1:0]         out_seq,
    output logic [arqsw_pkg::TAG_W-1:0]         out_tag,
    output logic                                out_last
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W  = arqsw_pkg::SEQ_W;
    localparam int TAG_W  = arqsw_pkg::TAG_W;
    localparam int TIME_W = arqsw_pkg::TIME_W;
    localparam int SLOT_DW = TAG_W + TIME_W;
    localparam logic [SEQ_W-1:0] W_SEQ = SEQ_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] W_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] WL_RESET =
        (int'(arqsw_pkg::INIT_WINDOW_RESET) > WINDOW_DEPTH) ? CNT_W'(WINDOW_DEPTH)
                                                             : CNT_W'(arqsw_pkg::INIT_WINDOW_RESET);

    // slot index arithmetic modulo the window depth
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W:0]   ofs);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + ofs;
        if (sum >= (SLOT_W+1)'(WINDOW_DEPTH))
        begin
            sum = sum - (SLOT_W+1)'(WINDOW_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cap_window(input logic [SEQ_W-1:0] w);
        return (w > W_SEQ) ? W_CNT : w[CNT_W-1:0];
    endfunction

    // captured beat
    logic [1:0]        act_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SEQ_W-1:0]  ack_reg;
    logic [SEQ_W-1:0]  space_reg;

    logic [arqsw_pkg::TOUT_W-1:0] timeout_reg;
    logic [SEQ_W-1:0]  base_reg;
    logic [SEQ_W-1:0]  next_seq_reg;
    logic [CNT_W-1:0]  wlimit_reg;
    logic [SLOT_W-1:0] base_slot_reg;
    logic              ack_seen_reg;
    logic [TIME_W-1:0] time_reg;
    logic [QA_W-1:0]   q_head_reg;
    logic [QC_W-1:0]   q_count_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic              pend_valid_reg;
    logic [1:0]        pend_kind_reg;
    logic [SEQ_W-1:0]  pend_seq_reg;
    logic [TAG_W-1:0]  pend_tag_reg;

    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [SEQ_W-1:0]  m_seq_reg;
    logic [TAG_W-1:0]  m_tag_reg;
    logic              m_last_reg;

    logic [SLOT_DW-1:0] slot_rdata;
    logic [TAG_W-1:0]   q_rdata;
    logic [SLOT_W-1:0]  rt_addr;
    logic [SLOT_W-1:0]  new_addr;
    logic [TIME_W-1:0]  age;
    logic               out_free;
    logic               q_full;
    logic [QA_W:0]      q_wsum;
    logic [QA_W-1:0]    q_waddr;
    logic [QA_W-1:0]    q_head_inc;
    logic [SEQ_W-1:0]   ack_dist;
    logic [SEQ_W-1:0]   outstanding;
    logic               ack_in_win;
    logic               ack_dup;
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr;
    logic [SLOT_DW-1:0] slot_wdata;
    logic               issue;
    logic [1:0]         new_kind;
    logic [SEQ_W-1:0]   new_seq;
    logic [TAG_W-1:0]   new_tag;

    assign out_free    = !m_valid_reg || out_ready;
    assign rt_addr     = slot_add(base_slot_reg, (SLOT_W+1)'(scan_idx_reg));
    assign new_addr    = slot_add(base_slot_reg, (SLOT_W+1)'(out_cnt_reg));
    assign age         = time_reg - slot_rdata[TIME_W-1:0];
    assign q_full      = (q_count_reg >= QC_W'(QUEUE_DEPTH));
    assign q_wsum      = {1'b0, q_head_reg} + (QA_W+1)'(q_count_reg);
    assign q_waddr     = (q_wsum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                         QA_W'(q_wsum - (QA_W+1)'(QUEUE_DEPTH)) : q_wsum[QA_W-1:0];
    assign q_head_inc  = (q_head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_reg + 1'b1;
    assign ack_dist    = ack_reg - base_reg;
    assign outstanding = next_seq_reg - base_reg;
    assign ack_in_win  = (ack_dist < SEQ_W'(wlimit_reg));
    assign ack_dup     = (ack_dist == '1);

    assign issue    = cmd.rt_issue || cmd.new_issue;
    assign new_kind = cmd.rt_issue ? 2'(arqsw_pkg::KIND_RESEND) : 2'(arqsw_pkg::KIND_SEND);
    assign new_seq  = cmd.rt_issue ? base_reg + SEQ_W'(scan_idx_reg) : next_seq_reg;
    assign new_tag  = cmd.rt_issue ? slot_rdata[SLOT_DW-1:TIME_W] : q_rdata;

    // a resend restamps its own slot, a new send fills the next free slot
    assign slot_we    = issue;
    assign slot_waddr = cmd.rt_issue ? rt_addr : new_addr;
    assign slot_wdata = {new_tag, time_reg};

    always_comb
    begin
        st.out_free   = out_free;
        st.can_push   = !pend_valid_reg || out_free;
        st.pend_valid = pend_valid_reg;
        st.rt_more    = (scan_idx_reg < out_cnt_reg);
        st.rt_expired = (age > TIME_W'(timeout_reg));
        st.new_more   = (out_cnt_reg < wlimit_reg) && (out_cnt_reg < W_CNT) &&
                        (q_count_reg != '0);
    end

    arqsw_ram #(.WIDTH(SLOT_DW), .DEPTH(WINDOW_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (cmd.rt_read),
        .raddr (rt_addr),
        .rdata (slot_rdata)
    );

    arqsw_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (cmd.enq && !q_full),
        .waddr (q_waddr),
        .wdata (tag_reg),
        .re    (cmd.new_read),
        .raddr (q_head_reg),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= in_action;
            tag_reg   <= in_data[15:0];
            ack_reg   <= in_data[23:16];
            space_reg <= in_data[31:24];
        end
        if (issue)
        begin
            pend_kind_reg <= new_kind;
            pend_seq_reg  <= new_seq;
            pend_tag_reg  <= new_tag;
        end
        if (cmd.enq)
        begin
            m_kind_reg <= q_full ? 2'(arqsw_pkg::KIND_REFUSED) : 2'(arqsw_pkg::KIND_TAKEN);
            m_seq_reg  <= '0;
            m_tag_reg  <= tag_reg;
            m_last_reg <= 1'b1;
        end
        else if ((issue && pend_valid_reg) || cmd.finish)
        begin
            m_kind_reg <= pend_kind_reg;
            m_seq_reg  <= pend_seq_reg;
            m_tag_reg  <= pend_tag_reg;
            m_last_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= arqsw_pkg::TIMEOUT_RESET;
            base_reg       <= '0;
            next_seq_reg   <= '0;
            wlimit_reg     <= WL_RESET;
            base_slot_reg  <= '0;
            ack_seen_reg   <= 1'b0;
            time_reg       <= '0;
            q_head_reg     <= '0;
            q_count_reg    <= '0;
            scan_idx_reg   <= '0;
            out_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == arqsw_pkg::CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg_wdata;
                end
                else if (cfg_idx == arqsw_pkg::CFG_INIT_WIN)
                begin
                    if (!ack_seen_reg)
                    begin
                        wlimit_reg <= cap_window(SEQ_W'(cfg_wdata[arqsw_pkg::INIT_W-1:0]));
                    end
                end
            end

            if (cmd.update)
            begin
                if (act_reg == 2'(arqsw_pkg::ACT_TICK))
                begin
                    time_reg <= time_reg + 1'b1;
                end
                else if (ack_in_win)
                begin
                    base_reg      <= ack_reg + 1'b1;
                    base_slot_reg <= slot_add(base_slot_reg,
                                              (SLOT_W+1)'(ack_dist) + 1'b1);
                    if (ack_dist >= outstanding)
                    begin
                        next_seq_reg <= ack_reg + 1'b1;
                    end
                    wlimit_reg   <= cap_window(space_reg);
                    ack_seen_reg <= 1'b1;
                end
                else if (ack_dup)
                begin
                    wlimit_reg   <= cap_window(space_reg);
                    ack_seen_reg <= 1'b1;
                end
            end

            if (cmd.enq && !q_full)
            begin
                q_count_reg <= q_count_reg + 1'b1;
            end

            if (cmd.scan_init)
            begin
                scan_idx_reg   <= '0;
                out_cnt_reg    <= (outstanding > W_SEQ) ? W_CNT : outstanding[CNT_W-1:0];
                pend_valid_reg <= 1'b0;
            end

            if (cmd.rt_skip || cmd.rt_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            if (cmd.new_issue)
            begin
                q_head_reg   <= q_head_inc;
                q_count_reg  <= q_count_reg - 1'b1;
                next_seq_reg <= next_seq_reg + 1'b1;
                out_cnt_reg  <= out_cnt_reg + 1'b1;
            end

            if (issue)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.enq || (issue && pend_valid_reg) || cmd.finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_seq   = m_seq_reg;
    assign out_tag   = m_tag_reg;
    assign out_last  = m_last_reg;

    `ARQSW_ASSERT(a_queue_bound, q_count_reg <= QC_W'(QUEUE_DEPTH), "send queue count over depth")
    `ARQSW_ASSERT(a_limit_bound, wlimit_reg <= W_CNT, "window limit over depth")
    `ARQSW_ASSERT(a_outstanding_bound, (next_seq_reg - base_reg) <= W_SEQ, "outstanding over depth")
    `ARQSW_ASSERT(a_scan_clears, cmd.scan_init |=> !pend_valid_reg, "stale result held into a scan")

endmodule

// File: src/arq_send_window.sv
// top level of the sliding window arq sender
`timescale 1ns / 1ps
// Sender side of a go-back-n sliding window for one connection with 8-bit sequence
// numbers. Input beats carry an action in s_tuser: enqueue a message tag, take an
// acknowledgment, advance the tick counter, or scan the window. An enqueue answers
// with one beat (taken or refused); ack and tick give none; a scan first resends,
// oldest first, each outstanding slot older than timeout_ticks, then issues queued
// tags under new sequence numbers while the window allows, ending on a tlast beat
// (no beat at all when nothing was due). Enqueue, ack and tick are accepted in idle
// and then executed in a state of their own, an enqueue waiting further while its
// result beat cannot leave. A scan checks the outstanding slots and then makes the
// new sends one at a time, set by the one-read-per-cycle slot and queue memories,
// and its result beats may also wait on m_tready.
// Slot and queue memories need no clearing after reset. Configuration writes are
// taken at any time (cfg_ready is always high) but belong in idle periods.
module arq_send_window #(
    parameter int WINDOW_DEPTH = arqsw_pkg::WINDOW_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = arqsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // message_tag, ack_number, advertised_space
    input  logic [1:0]                       s_tuser,   // action
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // sequence_res, payload_tag
    output logic [1:0]                       m_tuser,   // kind
    output logic                             m_tlast,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arqsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arqsw_pkg::CFG_DATA_W-1:0] cfg_data
);

    arqsw_pkg::cmd_t    cmd;
    arqsw_pkg::status_t st;
    logic [arqsw_pkg::SEQ_W-1:0] out_seq;
    logic [arqsw_pkg::TAG_W-1:0] out_tag;

    // register writes never stall
    assign cfg_ready = 1'b1;

    arqsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .st        (st),
        .cmd       (cmd)
    );

    arqsw_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_tdata),
        .in_action (s_tuser),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_seq   (out_seq),
        .out_tag   (out_tag),
        .out_last  (m_tlast)
    );

    // sequence number in the low byte, tag above it
    assign m_tdata = {out_tag, out_seq};

endmodule
